[src/vpz_pkg.sv]
// Package for the viewport pan/zoom transform: widths, fixed-point constants,
// operation and register codes, and the structs between the top level and the serial unit.
// No dependencies.
package vpz_pkg;

   localparam int FRAC_BITS = 16;
   localparam int COORD_W   = 32;
   localparam int ZOOM_W    = 23;
   localparam int VIEW_W    = 14;
   localparam int MAX_VIEW  = 8192;
   localparam int CSR_IDX_W = 2;

   localparam int NUM_W     = COORD_W + FRAC_BITS;
   localparam int RES_W     = 40;
   localparam int SUM_W     = 44;
   localparam int DIFF_W    = COORD_W + 2;
   localparam int HALF_W    = VIEW_W - 1 + FRAC_BITS;
   localparam int ZMUL_W    = ZOOM_W + 3;

   localparam int DIV_STEPS = NUM_W;
   localparam int MUL_STEPS = ZOOM_W;
   localparam int LO_W      = MUL_STEPS - FRAC_BITS;
   localparam int CNT_W     = $clog2(NUM_W);

   localparam int ONE_FX     = 1 << FRAC_BITS;
   localparam int ZOOM_FLOOR = ONE_FX / 100;
   localparam int ZOOM_CEIL  = ONE_FX * 100;
   localparam int ZOOM_DEN_UP   = 9;
   localparam int ZOOM_DEN_DOWN = 10;

   localparam logic [CSR_IDX_W-1:0] CSR_VIEW_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_VIEW_HEIGHT = CSR_IDX_W'(1);

   typedef enum logic [1:0] {
      OP_PAN,
      OP_ZOOM,
      OP_W2S,
      OP_S2W
   } op_type;

   typedef struct packed {
      logic              start;
      logic              mul;
      logic [NUM_W-1:0]  num;
      logic [ZOOM_W-1:0] den;
   } lane_cmd_type;

   typedef struct packed {
      logic             done;
      logic [RES_W-1:0] mag;
   } lane_res_type;

endpackage

[src/vpz_if.sv]
// Valid/ready channel interfaces for the request and response transfers.
// Depends on vpz_pkg for the field widths.
interface vpz_req_if import vpz_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [1:0]                op;
   logic signed [COORD_W-1:0] in_x;
   logic signed [COORD_W-1:0] in_y;
   logic                      wheel_up;

   modport source (output valid, output op, output in_x, output in_y, output wheel_up,
                   input ready);
   modport sink   (input valid, input op, input in_x, input in_y, input wheel_up,
                   output ready);
endinterface

interface vpz_rsp_if import vpz_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] res_x;
   logic signed [COORD_W-1:0] res_y;
   logic [ZOOM_W-1:0]         zoom_out;

   modport source (output valid, output res_x, output res_y, output zoom_out,
                   input ready);
   modport sink   (input valid, input res_x, input res_y, input zoom_out,
                   output ready);
endinterface

[src/vpz_serial_unit.sv]
// Bit-serial arithmetic unit: restoring divide, one quotient bit per cycle, or
// shift-add multiply, one multiplier bit per cycle. Depends on vpz_pkg.
module vpz_serial_unit import vpz_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  lane_cmd_type cmd,
   output lane_res_type res
);

   logic               busy_ff;
   logic               done_ff;
   logic               mul_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [NUM_W-1:0]   num_ff;
   logic [ZOOM_W-1:0]  den_ff;
   logic [COORD_W-1:0] acc_ff;
   logic [LO_W-1:0]    lo_ff;

   logic [NUM_W-1:0]   num_in;
   logic [ZOOM_W-1:0]  den_in;
   logic [COORD_W-1:0] acc_in;
   logic [LO_W-1:0]    lo_in;

   logic [ZOOM_W:0]    div_part;
   logic [ZOOM_W:0]    div_diff;
   logic               div_ge;
   logic [COORD_W:0]   mul_sum;

   always_comb begin
      div_part = {acc_ff[ZOOM_W-1:0], num_ff[NUM_W-1]};
      div_diff = div_part - {1'b0, den_ff};
      div_ge   = (div_part >= {1'b0, den_ff});
      mul_sum  = {1'b0, acc_ff}
               + (den_ff[0] ? {1'b0, num_ff[NUM_W-1:FRAC_BITS]} : {(COORD_W + 1){1'b0}});
      if (mul_ff) begin
         num_in = num_ff;
         den_in = den_ff >> 1;
         acc_in = mul_sum[COORD_W:1];
         lo_in  = {mul_sum[0], lo_ff[LO_W-1:1]};
      end else begin
         num_in = {num_ff[NUM_W-2:0], div_ge};
         den_in = den_ff;
         acc_in = COORD_W'(div_ge ? div_diff[ZOOM_W-1:0] : div_part[ZOOM_W-1:0]);
         lo_in  = lo_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff <= 1'b1;
            mul_ff  <= cmd.mul;
            cnt_ff  <= cmd.mul ? CNT_W'(MUL_STEPS - 1) : CNT_W'(DIV_STEPS - 1);
            num_ff  <= cmd.num;
            den_ff  <= cmd.den;
            acc_ff  <= '0;
            lo_ff   <= '0;
         end else if (busy_ff) begin
            num_ff <= num_in;
            den_ff <= den_in;
            acc_ff <= acc_in;
            lo_ff  <= lo_in;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff - 1'b1;
            end
         end
      end
   end

   assign res.done = done_ff;
   assign res.mag  = mul_ff ? RES_W'({acc_ff, lo_ff}) : num_ff[RES_W-1:0];

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !busy_ff)
      else $error("serial unit started while busy");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("serial unit done while still busy");

   a_last_step: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !cmd.start && cnt_ff == '0) |=> done_ff)
      else $error("serial unit missed its done pulse");

endmodule

[src/viewport_pan_zoom_transform.sv]
// Viewport pan/zoom transform. Pan and screen-to-world each run one 48-step divide,
// world-to-screen runs one 23-step multiply, and zoom at cursor runs three 48-step divides
// in sequence. One item at a time: the next request is taken only after the last result
// has moved into the response register.
// Synchronous reset clears camera to the origin, zoom to 1.0 and the view size to zero.
module viewport_pan_zoom_transform import vpz_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [VIEW_W-1:0]    csr_wdata,
   vpz_req_if.sink              req_if,
   vpz_rsp_if.source            rsp_if
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_START1,
      S_WAIT1,
      S_START_Z,
      S_WAIT_Z,
      S_START2,
      S_WAIT2,
      S_FINAL
   } state_type;

   state_type                 state_ff;
   logic [VIEW_W-1:0]         view_w_ff;
   logic [VIEW_W-1:0]         view_h_ff;
   logic signed [COORD_W-1:0] cam_x_ff;
   logic signed [COORD_W-1:0] cam_y_ff;
   logic [ZOOM_W-1:0]         zoom_ff;
   logic [1:0]                op_ff;
   logic signed [COORD_W-1:0] in_x_ff;
   logic signed [COORD_W-1:0] in_y_ff;
   logic                      up_ff;
   logic signed [SUM_W-1:0]   term_x_ff;
   logic signed [SUM_W-1:0]   term_y_ff;
   logic                      rsp_valid_ff;
   logic signed [COORD_W-1:0] res_x_ff;
   logic signed [COORD_W-1:0] res_y_ff;
   logic [ZOOM_W-1:0]         zoom_out_ff;

   logic [VIEW_W-1:0]         view_in;
   logic [HALF_W-1:0]         half_w;
   logic [HALF_W-1:0]         half_h;
   logic signed [DIFF_W-1:0]  d_x;
   logic signed [DIFF_W-1:0]  d_y;
   logic                      neg_x;
   logic                      neg_y;
   logic [DIFF_W-1:0]         abs_x;
   logic [DIFF_W-1:0]         abs_y;
   logic [ZMUL_W-1:0]         zoom_mul;
   logic                      flip;
   logic signed [SUM_W-1:0]   sv_x;
   logic signed [SUM_W-1:0]   sv_y;
   logic [ZOOM_W-1:0]         zoom_in;
   logic signed [SUM_W-1:0]   base_x;
   logic signed [SUM_W-1:0]   base_y;
   logic signed [COORD_W-1:0] res_x_in;
   logic signed [COORD_W-1:0] res_y_in;
   logic                      out_free;
   logic                      run_state;
   lane_cmd_type              x_cmd;
   lane_cmd_type              y_cmd;
   lane_res_type              x_res;
   lane_res_type              y_res;

   function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] hi;
      logic signed [SUM_W-1:0] lo;
      hi = SUM_W'((64'sd1 <<< (COORD_W - 1)) - 64'sd1);
      lo = -hi - SUM_W'(1);
      if (v > hi) begin
         return hi[COORD_W-1:0];
      end else if (v < lo) begin
         return lo[COORD_W-1:0];
      end else begin
         return v[COORD_W-1:0];
      end
   endfunction

   // A register value above the largest view is stored as the largest view.
   assign view_in = (csr_wdata > VIEW_W'(MAX_VIEW)) ? VIEW_W'(MAX_VIEW) : csr_wdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         view_w_ff <= '0;
         view_h_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_VIEW_WIDTH: begin
               view_w_ff <= view_in;
            end
            CSR_VIEW_HEIGHT: begin
               view_h_ff <= view_in;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      half_w = {view_w_ff[VIEW_W-1:1], {FRAC_BITS{1'b0}}};
      half_h = {view_h_ff[VIEW_W-1:1], {FRAC_BITS{1'b0}}};
      case (op_ff)
         OP_PAN: begin
            d_x = DIFF_W'(in_x_ff);
            d_y = DIFF_W'(in_y_ff);
         end
         OP_W2S: begin
            d_x = DIFF_W'(cam_x_ff) - DIFF_W'(in_x_ff);
            d_y = DIFF_W'(cam_y_ff) - DIFF_W'(in_y_ff);
         end
         default: begin
            d_x = DIFF_W'(in_x_ff) - $signed(DIFF_W'(half_w));
            d_y = DIFF_W'(in_y_ff) - $signed(DIFF_W'(half_h));
         end
      endcase
      neg_x = d_x[DIFF_W-1];
      neg_y = d_y[DIFF_W-1];
      abs_x = neg_x ? (~d_x + 1'b1) : d_x;
      abs_y = neg_y ? (~d_y + 1'b1) : d_y;

      zoom_mul = up_ff ? ({zoom_ff, 3'b000} + {2'b00, zoom_ff, 1'b0})
                       : ({zoom_ff, 3'b000} + {3'b000, zoom_ff});

      run_state = (state_ff == S_START1) || (state_ff == S_START2);

      x_cmd.start = run_state || (state_ff == S_START_Z);
      x_cmd.mul   = run_state && (op_ff == OP_W2S);
      x_cmd.num   = (state_ff == S_START_Z) ? NUM_W'(zoom_mul)
                                            : {abs_x[COORD_W-1:0], {FRAC_BITS{1'b0}}};
      x_cmd.den   = (state_ff == S_START_Z)
                  ? (up_ff ? ZOOM_W'(ZOOM_DEN_UP) : ZOOM_W'(ZOOM_DEN_DOWN))
                  : zoom_ff;

      y_cmd.start = run_state;
      y_cmd.mul   = run_state && (op_ff == OP_W2S);
      y_cmd.num   = {abs_y[COORD_W-1:0], {FRAC_BITS{1'b0}}};
      y_cmd.den   = zoom_ff;

      sv_x = neg_x ? -$signed(SUM_W'(x_res.mag)) : $signed(SUM_W'(x_res.mag));
      sv_y = neg_y ? -$signed(SUM_W'(y_res.mag)) : $signed(SUM_W'(y_res.mag));
      flip = (op_ff == OP_S2W) || (op_ff == OP_ZOOM);

      if (x_res.mag < RES_W'(ZOOM_FLOOR)) begin
         zoom_in = ZOOM_W'(ZOOM_FLOOR);
      end else if (x_res.mag > RES_W'(ZOOM_CEIL)) begin
         zoom_in = ZOOM_W'(ZOOM_CEIL);
      end else begin
         zoom_in = x_res.mag[ZOOM_W-1:0];
      end

      base_x = (op_ff == OP_W2S) ? $signed(SUM_W'(half_w)) : SUM_W'(cam_x_ff);
      base_y = (op_ff == OP_W2S) ? $signed(SUM_W'(half_h)) : SUM_W'(cam_y_ff);
      res_x_in = sat_coord(base_x + term_x_ff);
      res_y_in = sat_coord(base_y + term_y_ff);
      out_free = !rsp_valid_ff || rsp_if.ready;
   end

   vpz_serial_unit u_lane_x (
      .clock (clock),
      .reset (reset),
      .cmd   (x_cmd),
      .res   (x_res)
   );

   vpz_serial_unit u_lane_y (
      .clock (clock),
      .reset (reset),
      .cmd   (y_cmd),
      .res   (y_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cam_x_ff     <= '0;
         cam_y_ff     <= '0;
         zoom_ff      <= ZOOM_W'(ONE_FX);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == S_FINAL && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_if.valid) begin
                  op_ff    <= req_if.op;
                  in_x_ff  <= req_if.in_x;
                  in_y_ff  <= req_if.in_y;
                  up_ff    <= req_if.wheel_up;
                  state_ff <= S_START1;
               end
            end
            S_START1: begin
               state_ff <= S_WAIT1;
            end
            S_WAIT1: begin
               if (x_res.done) begin
                  term_x_ff <= flip ? sv_x : -sv_x;
                  term_y_ff <= flip ? -sv_y : sv_y;
                  state_ff  <= (op_ff == OP_ZOOM) ? S_START_Z : S_FINAL;
               end
            end
            S_START_Z: begin
               state_ff <= S_WAIT_Z;
            end
            S_WAIT_Z: begin
               if (x_res.done) begin
                  zoom_ff  <= zoom_in;
                  state_ff <= S_START2;
               end
            end
            S_START2: begin
               state_ff <= S_WAIT2;
            end
            S_WAIT2: begin
               if (x_res.done) begin
                  term_x_ff <= term_x_ff - sv_x;
                  term_y_ff <= term_y_ff + sv_y;
                  state_ff  <= S_FINAL;
               end
            end
            S_FINAL: begin
               if (out_free) begin
                  res_x_ff    <= res_x_in;
                  res_y_ff    <= res_y_in;
                  zoom_out_ff <= zoom_ff;
                  if (op_ff == OP_PAN || op_ff == OP_ZOOM) begin
                     cam_x_ff <= res_x_in;
                     cam_y_ff <= res_y_in;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_if.ready    = (state_ff == S_IDLE);
   assign rsp_if.valid    = rsp_valid_ff;
   assign rsp_if.res_x    = res_x_ff;
   assign rsp_if.res_y    = res_y_ff;
   assign rsp_if.zoom_out = zoom_out_ff;

   a_zoom_range: assert property (@(posedge clock) disable iff (reset)
      zoom_ff >= ZOOM_W'(ZOOM_FLOOR) && zoom_ff <= ZOOM_W'(ZOOM_CEIL))
      else $error("zoom level left its clamp range");

   a_lanes_together: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WAIT1 || state_ff == S_WAIT2) |-> (x_res.done == y_res.done))
      else $error("x and y lanes finished in different cycles");

   a_mapping_keeps_camera: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINAL && out_free && (op_ff == OP_W2S || op_ff == OP_S2W))
      |=> ($stable(cam_x_ff) && $stable(cam_y_ff)))
      else $error("point mapping changed the camera position");

   a_zoom_only_on_zoom_op: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WAIT_Z) |-> (op_ff == OP_ZOOM))
      else $error("zoom update entered for an operation other than zoom");

endmodule
